@@ rtl/core/imuobs_pkg.sv @@
// Shared types, register codes and the microprogram of the IMU bias observer.
// Used by every module under rtl/core; depends on nothing else.

package imuobs_pkg;

    typedef struct packed {
        logic signed [31:0] accel_x;
        logic signed [31:0] accel_y;
        logic signed [31:0] accel_z;
        logic signed [31:0] rate_x;
        logic signed [31:0] rate_y;
        logic signed [31:0] rate_z;
    } t_in;

    typedef struct packed {
        logic signed [31:0] est_accel_x;
        logic signed [31:0] est_accel_y;
        logic signed [31:0] est_accel_z;
        logic signed [31:0] accel_bias_x;
        logic signed [31:0] accel_bias_y;
        logic signed [31:0] accel_bias_z;
        logic signed [31:0] rate_bias_x;
        logic signed [31:0] rate_bias_y;
        logic signed [31:0] rate_bias_z;
        logic signed [31:0] offset_bias_x;
        logic signed [31:0] offset_bias_y;
        logic signed [31:0] offset_bias_z;
    } t_out;

    localparam int CFG_W    = 31;
    localparam int PADDR_W  = 5;

    typedef enum logic [2:0] {
        REG_GAIN_EST         = 3'd0,
        REG_GAIN_ACC_BIAS    = 3'd1,
        REG_GAIN_RATE_BIAS   = 3'd2,
        REG_GAIN_OFFSET_BIAS = 3'd3,
        REG_STEP_TIME        = 3'd4
    } t_reg;

    typedef struct packed {
        logic [CFG_W-1:0] gain_est;
        logic [CFG_W-1:0] gain_acc_bias;
        logic [CFG_W-1:0] gain_rate_bias;
        logic [CFG_W-1:0] gain_offset_bias;
        logic [CFG_W-1:0] step_time;
    } t_cfg;

    // Operand sources and writeback targets of the shared unit
    typedef enum logic [5:0] {
        SEL_ZERO, SEL_ONE,
        SEL_K1, SEL_K2, SEL_K3, SEL_K4, SEL_ST,
        SEL_A0, SEL_A1, SEL_A2,
        SEL_W0, SEL_W1, SEL_W2,
        SEL_E0, SEL_E1, SEL_E2,
        SEL_BA0, SEL_BA1, SEL_BA2,
        SEL_BW0, SEL_BW1, SEL_BW2,
        SEL_BZ0, SEL_BZ1, SEL_BZ2,
        SEL_DA0, SEL_DA1, SEL_DA2,
        SEL_DE0, SEL_DE1, SEL_DE2,
        SEL_T0, SEL_T1, SEL_T2
    } t_sel;

    typedef struct packed {
        t_sel src_a;
        t_sel src_b;
        logic clr;
        logic neg;
        logic wb;
        t_sel dest;
    } t_uop;

    typedef struct packed {
        logic               en;
        t_sel               dest;
        logic signed [31:0] data;
    } t_wb;

    localparam int UCODE_LEN = 84;
    localparam int PC_W      = $clog2(UCODE_LEN);

    typedef struct packed {
        logic cap;
        logic init;
        logic issue;
        logic load_out;
        t_uop uop;
    } t_seq_ctl;

    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

    function automatic t_uop mk(t_sel a, t_sel b, logic clr, logic neg, logic wb, t_sel dest);
        t_uop u;
        u.src_a = a;
        u.src_b = b;
        u.clr   = clr;
        u.neg   = neg;
        u.wb    = wb;
        u.dest  = dest;
        return u;
    endfunction

    // Each step: acc = (clr ? 0 : acc) +/- floor(a*b); write sat(acc) to dest when wb.
    // A value written by one step is read no earlier than two steps later.
    function automatic t_uop ucode(logic [PC_W-1:0] pc);
        t_uop u;
        case (pc)
            // da = e - a
            0:  u = mk(SEL_E0,  SEL_ONE, 1'b1, 1'b0, 1'b0, SEL_ZERO);
            1:  u = mk(SEL_A0,  SEL_ONE, 1'b0, 1'b1, 1'b1, SEL_DA0);
            2:  u = mk(SEL_E1,  SEL_ONE, 1'b1, 1'b0, 1'b0, SEL_ZERO);
            3:  u = mk(SEL_A1,  SEL_ONE, 1'b0, 1'b1, 1'b1, SEL_DA1);
            4:  u = mk(SEL_E2,  SEL_ONE, 1'b1, 1'b0, 1'b0, SEL_ZERO);
            5:  u = mk(SEL_A2,  SEL_ONE, 1'b0, 1'b1, 1'b1, SEL_DA2);
            // de x: w x e, w x ba, a x bw, then the five-term sum
            6:  u = mk(SEL_W1,  SEL_E2,  1'b1, 1'b0, 1'b0, SEL_ZERO);
            7:  u = mk(SEL_W2,  SEL_E1,  1'b0, 1'b1, 1'b1, SEL_T0);
            8:  u = mk(SEL_W1,  SEL_BA2, 1'b1, 1'b0, 1'b0, SEL_ZERO);
            9:  u = mk(SEL_W2,  SEL_BA1, 1'b0, 1'b1, 1'b1, SEL_T1);
            10: u = mk(SEL_A1,  SEL_BW2, 1'b1, 1'b0, 1'b0, SEL_ZERO);
            11: u = mk(SEL_A2,  SEL_BW1, 1'b0, 1'b1, 1'b1, SEL_T2);
            12: u = mk(SEL_T0,  SEL_ONE, 1'b1, 1'b1, 1'b0, SEL_ZERO);
            13: u = mk(SEL_T1,  SEL_ONE, 1'b0, 1'b0, 1'b0, SEL_ZERO);
            14: u = mk(SEL_T2,  SEL_ONE, 1'b0, 1'b1, 1'b0, SEL_ZERO);
            15: u = mk(SEL_BZ0, SEL_ONE, 1'b0, 1'b1, 1'b0, SEL_ZERO);
            16: u = mk(SEL_K1,  SEL_DA0, 1'b0, 1'b1, 1'b1, SEL_DE0);
            // de y
            17: u = mk(SEL_W2,  SEL_E0,  1'b1, 1'b0, 1'b0, SEL_ZERO);
            18: u = mk(SEL_W0,  SEL_E2,  1'b0, 1'b1, 1'b1, SEL_T0);
            19: u = mk(SEL_W2,  SEL_BA0, 1'b1, 1'b0, 1'b0, SEL_ZERO);
            20: u = mk(SEL_W0,  SEL_BA2, 1'b0, 1'b1, 1'b1, SEL_T1);
            21: u = mk(SEL_A2,  SEL_BW0, 1'b1, 1'b0, 1'b0, SEL_ZERO);
            22: u = mk(SEL_A0,  SEL_BW2, 1'b0, 1'b1, 1'b1, SEL_T2);
            23: u = mk(SEL_T0,  SEL_ONE, 1'b1, 1'b1, 1'b0, SEL_ZERO);
            24: u = mk(SEL_T1,  SEL_ONE, 1'b0, 1'b0, 1'b0, SEL_ZERO);
            25: u = mk(SEL_T2,  SEL_ONE, 1'b0, 1'b1, 1'b0, SEL_ZERO);
            26: u = mk(SEL_BZ1, SEL_ONE, 1'b0, 1'b1, 1'b0, SEL_ZERO);
            27: u = mk(SEL_K1,  SEL_DA1, 1'b0, 1'b1, 1'b1, SEL_DE1);
            // de z
            28: u = mk(SEL_W0,  SEL_E1,  1'b1, 1'b0, 1'b0, SEL_ZERO);
            29: u = mk(SEL_W1,  SEL_E0,  1'b0, 1'b1, 1'b1, SEL_T0);
            30: u = mk(SEL_W0,  SEL_BA1, 1'b1, 1'b0, 1'b0, SEL_ZERO);
            31: u = mk(SEL_W1,  SEL_BA0, 1'b0, 1'b1, 1'b1, SEL_T1);
            32: u = mk(SEL_A0,  SEL_BW1, 1'b1, 1'b0, 1'b0, SEL_ZERO);
            33: u = mk(SEL_A1,  SEL_BW0, 1'b0, 1'b1, 1'b1, SEL_T2);
            34: u = mk(SEL_T0,  SEL_ONE, 1'b1, 1'b1, 1'b0, SEL_ZERO);
            35: u = mk(SEL_T1,  SEL_ONE, 1'b0, 1'b0, 1'b0, SEL_ZERO);
            36: u = mk(SEL_T2,  SEL_ONE, 1'b0, 1'b1, 1'b0, SEL_ZERO);
            37: u = mk(SEL_BZ2, SEL_ONE, 1'b0, 1'b1, 1'b0, SEL_ZERO);
            38: u = mk(SEL_K1,  SEL_DA2, 1'b0, 1'b1, 1'b1, SEL_DE2);
            // e += dt * de
            39: u = mk(SEL_E0,  SEL_ONE, 1'b1, 1'b0, 1'b0, SEL_ZERO);
            40: u = mk(SEL_ST,  SEL_DE0, 1'b0, 1'b0, 1'b1, SEL_E0);
            41: u = mk(SEL_E1,  SEL_ONE, 1'b1, 1'b0, 1'b0, SEL_ZERO);
            42: u = mk(SEL_ST,  SEL_DE1, 1'b0, 1'b0, 1'b1, SEL_E1);
            43: u = mk(SEL_E2,  SEL_ONE, 1'b1, 1'b0, 1'b0, SEL_ZERO);
            44: u = mk(SEL_ST,  SEL_DE2, 1'b0, 1'b0, 1'b1, SEL_E2);
            // accel bias: w x da, times k2, integrate
            45: u = mk(SEL_W1,  SEL_DA2, 1'b1, 1'b0, 1'b0, SEL_ZERO);
            46: u = mk(SEL_W2,  SEL_DA1, 1'b0, 1'b1, 1'b1, SEL_T0);
            47: u = mk(SEL_W2,  SEL_DA0, 1'b1, 1'b0, 1'b0, SEL_ZERO);
            48: u = mk(SEL_W0,  SEL_DA2, 1'b0, 1'b1, 1'b1, SEL_T1);
            49: u = mk(SEL_W0,  SEL_DA1, 1'b1, 1'b0, 1'b0, SEL_ZERO);
            50: u = mk(SEL_W1,  SEL_DA0, 1'b0, 1'b1, 1'b1, SEL_T2);
            51: u = mk(SEL_K2,  SEL_T0,  1'b1, 1'b0, 1'b1, SEL_T0);
            52: u = mk(SEL_K2,  SEL_T1,  1'b1, 1'b0, 1'b1, SEL_T1);
            53: u = mk(SEL_K2,  SEL_T2,  1'b1, 1'b0, 1'b1, SEL_T2);
            54: u = mk(SEL_BA0, SEL_ONE, 1'b1, 1'b0, 1'b0, SEL_ZERO);
            55: u = mk(SEL_ST,  SEL_T0,  1'b0, 1'b0, 1'b1, SEL_BA0);
            56: u = mk(SEL_BA1, SEL_ONE, 1'b1, 1'b0, 1'b0, SEL_ZERO);
            57: u = mk(SEL_ST,  SEL_T1,  1'b0, 1'b0, 1'b1, SEL_BA1);
            58: u = mk(SEL_BA2, SEL_ONE, 1'b1, 1'b0, 1'b0, SEL_ZERO);
            59: u = mk(SEL_ST,  SEL_T2,  1'b0, 1'b0, 1'b1, SEL_BA2);
            // gyro bias: a x da, times -k3, integrate
            60: u = mk(SEL_A1,  SEL_DA2, 1'b1, 1'b0, 1'b0, SEL_ZERO);
            61: u = mk(SEL_A2,  SEL_DA1, 1'b0, 1'b1, 1'b1, SEL_T0);
            62: u = mk(SEL_A2,  SEL_DA0, 1'b1, 1'b0, 1'b0, SEL_ZERO);
            63: u = mk(SEL_A0,  SEL_DA2, 1'b0, 1'b1, 1'b1, SEL_T1);
            64: u = mk(SEL_A0,  SEL_DA1, 1'b1, 1'b0, 1'b0, SEL_ZERO);
            65: u = mk(SEL_A1,  SEL_DA0, 1'b0, 1'b1, 1'b1, SEL_T2);
            66: u = mk(SEL_K3,  SEL_T0,  1'b1, 1'b1, 1'b1, SEL_T0);
            67: u = mk(SEL_K3,  SEL_T1,  1'b1, 1'b1, 1'b1, SEL_T1);
            68: u = mk(SEL_K3,  SEL_T2,  1'b1, 1'b1, 1'b1, SEL_T2);
            69: u = mk(SEL_BW0, SEL_ONE, 1'b1, 1'b0, 1'b0, SEL_ZERO);
            70: u = mk(SEL_ST,  SEL_T0,  1'b0, 1'b0, 1'b1, SEL_BW0);
            71: u = mk(SEL_BW1, SEL_ONE, 1'b1, 1'b0, 1'b0, SEL_ZERO);
            72: u = mk(SEL_ST,  SEL_T1,  1'b0, 1'b0, 1'b1, SEL_BW1);
            73: u = mk(SEL_BW2, SEL_ONE, 1'b1, 1'b0, 1'b0, SEL_ZERO);
            74: u = mk(SEL_ST,  SEL_T2,  1'b0, 1'b0, 1'b1, SEL_BW2);
            // offset bias: k4 * da, integrate
            75: u = mk(SEL_K4,  SEL_DA0, 1'b1, 1'b0, 1'b1, SEL_T0);
            76: u = mk(SEL_K4,  SEL_DA1, 1'b1, 1'b0, 1'b1, SEL_T1);
            77: u = mk(SEL_K4,  SEL_DA2, 1'b1, 1'b0, 1'b1, SEL_T2);
            78: u = mk(SEL_BZ0, SEL_ONE, 1'b1, 1'b0, 1'b0, SEL_ZERO);
            79: u = mk(SEL_ST,  SEL_T0,  1'b0, 1'b0, 1'b1, SEL_BZ0);
            80: u = mk(SEL_BZ1, SEL_ONE, 1'b1, 1'b0, 1'b0, SEL_ZERO);
            81: u = mk(SEL_ST,  SEL_T1,  1'b0, 1'b0, 1'b1, SEL_BZ1);
            82: u = mk(SEL_BZ2, SEL_ONE, 1'b1, 1'b0, 1'b0, SEL_ZERO);
            83: u = mk(SEL_ST,  SEL_T2,  1'b0, 1'b0, 1'b1, SEL_BZ2);
            default: u = mk(SEL_ZERO, SEL_ZERO, 1'b1, 1'b0, 1'b0, SEL_ZERO);
        endcase
        return u;
    endfunction

endpackage

@@ rtl/core/imuobs_cfg.sv @@
// APB-style configuration registers of the IMU bias observer.
// Depends on imuobs_pkg for the register codes and the t_cfg struct.

module imuobs_cfg
    import imuobs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg r_cfg;
    t_reg idx;
    logic wr_en;

    assign idx    = t_reg'(paddr[PADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_est         <= CFG_W'(65536);
            r_cfg.gain_acc_bias    <= CFG_W'(65536);
            r_cfg.gain_rate_bias   <= CFG_W'(65536);
            r_cfg.gain_offset_bias <= CFG_W'(65536);
            r_cfg.step_time        <= CFG_W'(66);
        end else if (wr_en) begin
            unique case (idx)
                REG_GAIN_EST:         r_cfg.gain_est         <= pwdata[CFG_W-1:0];
                REG_GAIN_ACC_BIAS:    r_cfg.gain_acc_bias    <= pwdata[CFG_W-1:0];
                REG_GAIN_RATE_BIAS:   r_cfg.gain_rate_bias   <= pwdata[CFG_W-1:0];
                REG_GAIN_OFFSET_BIAS: r_cfg.gain_offset_bias <= pwdata[CFG_W-1:0];
                REG_STEP_TIME:        r_cfg.step_time        <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_GAIN_EST:         prdata = {1'b0, r_cfg.gain_est};
            REG_GAIN_ACC_BIAS:    prdata = {1'b0, r_cfg.gain_acc_bias};
            REG_GAIN_RATE_BIAS:   prdata = {1'b0, r_cfg.gain_rate_bias};
            REG_GAIN_OFFSET_BIAS: prdata = {1'b0, r_cfg.gain_offset_bias};
            REG_STEP_TIME:        prdata = {1'b0, r_cfg.step_time};
            default:              prdata = '0;
        endcase
    end

endmodule

@@ rtl/core/imuobs_seq.sv @@
// Sequencer: item handshake, microprogram counter and first-sample flag.
// Depends on imuobs_pkg for the microprogram and control struct.

module imuobs_seq
    import imuobs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_seq_ctl o_ctl
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_FIN   = 4'b1000
    } t_state;

    t_state          r_state, n_state;
    logic [PC_W-1:0] r_pc, n_pc;
    logic            r_started, n_started;
    logic            r_out_valid, n_out_valid;
    logic            accept;
    logic            load_out;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_pc        = r_pc;
        n_started   = r_started;
        n_out_valid = r_out_valid && !i_out_ready;
        load_out    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_pc = '0;
                    if (r_started) begin
                        n_state = ST_RUN;
                    end else begin
                        // first sample only loads the estimate
                        n_started = 1'b1;
                        n_state   = ST_FIN;
                    end
                end
            end
            ST_RUN: begin
                if (r_pc == PC_W'(UCODE_LEN - 1)) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_pc = r_pc + 1'b1;
                end
            end
            ST_DRAIN: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pc        <= '0;
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_started   <= n_started;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ctl.cap      = accept;
    assign o_ctl.init     = accept && !r_started;
    assign o_ctl.issue    = (r_state == ST_RUN);
    assign o_ctl.load_out = load_out;
    assign o_ctl.uop      = ucode(r_pc);

endmodule

@@ rtl/core/imuobs_mac.sv @@
// Shared multiply-accumulate unit: registered 32x32 product, floor shift,
// accumulate with saturating writeback. Depends on imuobs_pkg.

module imuobs_mac
    import imuobs_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_issue,
    input  t_uop               i_uop,
    input  logic signed [31:0] i_opa,
    input  logic signed [31:0] i_opb,
    output t_wb                o_wb
);

    logic signed [63:0] prod;
    logic signed [63:0] r_prod;
    t_uop               r_uop;
    logic               r_v;
    logic signed [63:0] r_acc;
    logic signed [63:0] shifted;
    logic signed [63:0] term;
    logic signed [63:0] acc_next;
    logic signed [31:0] sat_val;

    assign prod = i_opa * i_opb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= i_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= prod;
        r_uop  <= i_uop;
        if (r_v) begin
            r_acc <= acc_next;
        end
    end

    always_comb begin
        shifted  = r_prod >>> FRAC_BITS;
        term     = r_uop.neg ? -shifted : shifted;
        acc_next = (r_uop.clr ? 64'sd0 : r_acc) + term;
        if (acc_next > SAT_MAX) begin
            sat_val = SAT_MAX[31:0];
        end else if (acc_next < SAT_MIN) begin
            sat_val = SAT_MIN[31:0];
        end else begin
            sat_val = acc_next[31:0];
        end
    end

    assign o_wb.en   = r_v && r_uop.wb;
    assign o_wb.dest = r_uop.dest;
    assign o_wb.data = sat_val;

endmodule

@@ rtl/core/imuobs_rf.sv @@
// Operand registers: sample, state vectors and temporaries, with the two
// operand selectors of the shared unit. Depends on imuobs_pkg.

module imuobs_rf
    import imuobs_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cap,
    input  logic               i_init,
    input  t_in                i_in,
    input  t_wb                i_wb,
    input  t_cfg               i_cfg,
    input  t_sel               i_sel_a,
    input  t_sel               i_sel_b,
    output logic signed [31:0] o_opa,
    output logic signed [31:0] o_opb,
    output t_out               o_state
);

    localparam logic signed [31:0] FX_ONE = 32'sd1 <<< FRAC_BITS;

    typedef struct packed {
        logic [2:0][31:0] a;
        logic [2:0][31:0] w;
        logic [2:0][31:0] e;
        logic [2:0][31:0] ba;
        logic [2:0][31:0] bw;
        logic [2:0][31:0] bz;
        logic [2:0][31:0] da;
        logic [2:0][31:0] de;
        logic [2:0][31:0] t;
    } t_srcs;

    logic [2:0][31:0] r_a, r_w, r_e, r_ba, r_bw, r_bz, r_da, r_de, r_t;
    t_srcs            srcs;

    function automatic logic signed [31:0] pick(t_sel s, t_srcs p, t_cfg c);
        logic [31:0] v;
        case (s)
            SEL_ZERO: v = '0;
            SEL_ONE:  v = FX_ONE;
            SEL_K1:   v = {1'b0, c.gain_est};
            SEL_K2:   v = {1'b0, c.gain_acc_bias};
            SEL_K3:   v = {1'b0, c.gain_rate_bias};
            SEL_K4:   v = {1'b0, c.gain_offset_bias};
            SEL_ST:   v = {1'b0, c.step_time};
            SEL_A0:   v = p.a[0];
            SEL_A1:   v = p.a[1];
            SEL_A2:   v = p.a[2];
            SEL_W0:   v = p.w[0];
            SEL_W1:   v = p.w[1];
            SEL_W2:   v = p.w[2];
            SEL_E0:   v = p.e[0];
            SEL_E1:   v = p.e[1];
            SEL_E2:   v = p.e[2];
            SEL_BA0:  v = p.ba[0];
            SEL_BA1:  v = p.ba[1];
            SEL_BA2:  v = p.ba[2];
            SEL_BW0:  v = p.bw[0];
            SEL_BW1:  v = p.bw[1];
            SEL_BW2:  v = p.bw[2];
            SEL_BZ0:  v = p.bz[0];
            SEL_BZ1:  v = p.bz[1];
            SEL_BZ2:  v = p.bz[2];
            SEL_DA0:  v = p.da[0];
            SEL_DA1:  v = p.da[1];
            SEL_DA2:  v = p.da[2];
            SEL_DE0:  v = p.de[0];
            SEL_DE1:  v = p.de[1];
            SEL_DE2:  v = p.de[2];
            SEL_T0:   v = p.t[0];
            SEL_T1:   v = p.t[1];
            SEL_T2:   v = p.t[2];
            default:  v = '0;
        endcase
        return $signed(v);
    endfunction

    assign srcs = '{a: r_a, w: r_w, e: r_e, ba: r_ba, bw: r_bw, bz: r_bz,
                    da: r_da, de: r_de, t: r_t};

    assign o_opa = pick(i_sel_a, srcs, i_cfg);
    assign o_opb = pick(i_sel_b, srcs, i_cfg);

    // state vectors
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e  <= '0;
            r_ba <= '0;
            r_bw <= '0;
            r_bz <= '0;
        end else begin
            if (i_init) begin
                r_e[0] <= i_in.accel_x;
                r_e[1] <= i_in.accel_y;
                r_e[2] <= i_in.accel_z;
            end
            if (i_wb.en) begin
                case (i_wb.dest)
                    SEL_E0:  r_e[0]  <= i_wb.data;
                    SEL_E1:  r_e[1]  <= i_wb.data;
                    SEL_E2:  r_e[2]  <= i_wb.data;
                    SEL_BA0: r_ba[0] <= i_wb.data;
                    SEL_BA1: r_ba[1] <= i_wb.data;
                    SEL_BA2: r_ba[2] <= i_wb.data;
                    SEL_BW0: r_bw[0] <= i_wb.data;
                    SEL_BW1: r_bw[1] <= i_wb.data;
                    SEL_BW2: r_bw[2] <= i_wb.data;
                    SEL_BZ0: r_bz[0] <= i_wb.data;
                    SEL_BZ1: r_bz[1] <= i_wb.data;
                    SEL_BZ2: r_bz[2] <= i_wb.data;
                    default: ;
                endcase
            end
        end
    end

    // sample and temporaries
    always_ff @(posedge i_clk) begin
        if (i_cap) begin
            r_a[0] <= i_in.accel_x;
            r_a[1] <= i_in.accel_y;
            r_a[2] <= i_in.accel_z;
            r_w[0] <= i_in.rate_x;
            r_w[1] <= i_in.rate_y;
            r_w[2] <= i_in.rate_z;
        end
        if (i_wb.en) begin
            case (i_wb.dest)
                SEL_DA0: r_da[0] <= i_wb.data;
                SEL_DA1: r_da[1] <= i_wb.data;
                SEL_DA2: r_da[2] <= i_wb.data;
                SEL_DE0: r_de[0] <= i_wb.data;
                SEL_DE1: r_de[1] <= i_wb.data;
                SEL_DE2: r_de[2] <= i_wb.data;
                SEL_T0:  r_t[0]  <= i_wb.data;
                SEL_T1:  r_t[1]  <= i_wb.data;
                SEL_T2:  r_t[2]  <= i_wb.data;
                default: ;
            endcase
        end
    end

    assign o_state.est_accel_x   = $signed(r_e[0]);
    assign o_state.est_accel_y   = $signed(r_e[1]);
    assign o_state.est_accel_z   = $signed(r_e[2]);
    assign o_state.accel_bias_x  = $signed(r_ba[0]);
    assign o_state.accel_bias_y  = $signed(r_ba[1]);
    assign o_state.accel_bias_z  = $signed(r_ba[2]);
    assign o_state.rate_bias_x   = $signed(r_bw[0]);
    assign o_state.rate_bias_y   = $signed(r_bw[1]);
    assign o_state.rate_bias_z   = $signed(r_bw[2]);
    assign o_state.offset_bias_x = $signed(r_bz[0]);
    assign o_state.offset_bias_y = $signed(r_bz[1]);
    assign o_state.offset_bias_z = $signed(r_bz[2]);

endmodule

@@ rtl/core/imu_accel_gyro_bias_observer.sv @@
// Top level of the IMU acceleration/bias observer.
// Depends on imuobs_pkg, imuobs_cfg, imuobs_seq, imuobs_rf and imuobs_mac.

// Takes one IMU sample (acceleration and angular rate, signed fixed point with
// FRAC_BITS fraction bits) per item and returns one item holding the updated
// acceleration estimate and the accelerometer, gyro and offset bias vectors.
// The first sample after reset only loads the estimate, and its result is
// registered by the finish state that follows acceptance. Every later sample
// runs an 84-step microprogram through a single multiply-accumulate unit (one
// 32x32 product per cycle, saturating writeback). The sequencer issues the
// steps in its run state, lets the product pipeline drain in its drain state
// and loads the output register in its finish state; the input is not ready
// until the sequencer is back in idle. A finished result waits in an output
// register, and the next item is accepted while it waits; a result that
// finds the output register still full holds the block until the waiting
// item is taken. The user must write the gains and the step time through
// the APB port only while the block is idle; the block itself does not
// enforce this.

module imu_accel_gyro_bias_observer
    import imuobs_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in                i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out               o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    t_cfg               cfg;
    t_seq_ctl           ctl;
    t_wb                wb;
    t_out               state;
    logic signed [31:0] opa, opb;
    t_out               r_out_data;

    imuobs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    imuobs_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_ctl       (ctl)
    );

    imuobs_rf #(
        .FRAC_BITS (FRAC_BITS)
    ) u_rf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cap   (ctl.cap),
        .i_init  (ctl.init),
        .i_in    (i_in_data),
        .i_wb    (wb),
        .i_cfg   (cfg),
        .i_sel_a (ctl.uop.src_a),
        .i_sel_b (ctl.uop.src_b),
        .o_opa   (opa),
        .o_opb   (opb),
        .o_state (state)
    );

    imuobs_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_issue (ctl.issue),
        .i_uop   (ctl.uop),
        .i_opa   (opa),
        .i_opb   (opb),
        .o_wb    (wb)
    );

    always_ff @(posedge i_clk) begin
        if (ctl.load_out) begin
            r_out_data <= state;
        end
    end

    assign o_out_data = r_out_data;

endmodule
